[design/assert_macros.svh]
// ----------------------------------------------------------------------------
// assert_macros.svh
// Assertion shorthands shared by the timed event table modules.
// ----------------------------------------------------------------------------
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Check a property at every rising clk edge while out of reset.
`define TET_ASSERT(label, prop, msg) \
	label: assert property (@(posedge clk) disable iff (!arst_n) prop) \
		else $error(msg);

// Check that a condition never holds.
`define TET_NEVER(label, cond, msg) \
	`TET_ASSERT(label, !(cond), msg)

`endif

[design/tet_pkg.sv]
// ----------------------------------------------------------------------------
// tet_pkg
// Types, codes and sizes shared by the timed event table modules.
// ----------------------------------------------------------------------------
package tet_pkg;

	// Table size and derived widths
	localparam int ENTRIES     = 16;
	localparam int MAX_RESULTS = 16;
	localparam int IDX_W       = (ENTRIES > 1) ? $clog2(ENTRIES) : 1;
	localparam int CNT_W       = $clog2(ENTRIES + 1);

	// Command queue between front and back
	localparam int QDEPTH = 2;
	localparam int QPTR_W = (QDEPTH > 1) ? $clog2(QDEPTH) : 1;
	localparam int QCNT_W = $clog2(QDEPTH + 1);

	// Item kinds
	typedef enum logic [1:0] {
		KIND_TICK = 2'd0,
		KIND_ADD  = 2'd1,
		KIND_ARM  = 2'd2,
		KIND_ACT  = 2'd3
	} kind_t;

	// Event types (codes 6 and 7 are stored but never serviced)
	localparam logic [2:0] EV_ONESHOT  = 3'd0;
	localparam logic [2:0] EV_DELAYED  = 3'd1;
	localparam logic [2:0] EV_COOLDOWN = 3'd2;
	localparam logic [2:0] EV_ONLOAD   = 3'd3;
	localparam logic [2:0] EV_ONCLEAR  = 3'd4;
	localparam logic [2:0] EV_REPEAT   = 3'd5;

	// Result status codes
	localparam logic [2:0] STAT_FIRED   = 3'd0;
	localparam logic [2:0] STAT_NOTHING = 3'd1;
	localparam logic [2:0] STAT_ADDED   = 3'd2;
	localparam logic [2:0] STAT_FULL    = 3'd3;
	localparam logic [2:0] STAT_WRITTEN = 3'd4;
	localparam logic [2:0] STAT_BADSLOT = 3'd5;

	// One table entry as stored in the entry RAM
	typedef struct packed {
		logic [2:0]  etype;
		logic        active;
		logic        armed;
		logic [31:0] due;
		logic [15:0] node;
		logic [31:0] delay;
		logic [31:0] period;
	} entry_t;

	localparam int ENTRY_W = $bits(entry_t);

	// Classified command handed from front to back
	typedef struct packed {
		kind_t       op;
		logic [31:0] now_ms;
		logic [63:0] secs;
		logic [2:0]  etype;
		logic [15:0] node;
		logic [31:0] delay;
		logic [31:0] period;
		logic [3:0]  slot;
		logic [31:0] due;
		logic        active_bit;
	} cmd_t;

	// Back-end sequencer states
	typedef enum logic [2:0] {
		BS_IDLE,
		BS_CMD,
		BS_RMW,
		BS_RESP,
		BS_WALK,
		BS_EVAL,
		BS_TEND
	} bstate_t;

endpackage

[design/tet_ram.sv]
// ----------------------------------------------------------------------------
// tet_ram
// Generic RAM: one write port, two read ports with registered read data.
// ----------------------------------------------------------------------------
module tet_ram #(
	parameter int WIDTH = 8,
	parameter int DEPTH = 16,
	localparam int AW = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
	input  logic             clk,
	input  logic             we,
	input  logic [AW-1:0]    waddr,
	input  logic [WIDTH-1:0] wdata,
	input  logic [AW-1:0]    raddr_a,
	output logic [WIDTH-1:0] rdata_a,
	input  logic [AW-1:0]    raddr_b,
	output logic [WIDTH-1:0] rdata_b
);

	logic [WIDTH-1:0] mem [DEPTH];

	// Write port
	always_ff @(posedge clk) begin
		if (we) begin
			mem[waddr] <= wdata;
		end
	end

	// Registered read ports
	always_ff @(posedge clk) begin
		rdata_a <= mem[raddr_a];
		rdata_b <= mem[raddr_b];
	end

endmodule

[design/tet_front.sv]
// ----------------------------------------------------------------------------
// tet_front
// Accepts input transfers, unpacks them into commands and queues them.
// ----------------------------------------------------------------------------
`include "assert_macros.svh"

module tet_front (
	input  logic          clk,
	input  logic          arst_n,
	input  logic          s_tvalid,
	output logic          s_tready,
	// now_ms, now_seconds_bits, event_type, target_node, event_delay,
	// period_ms, slot, due_ms, active_bit
	input  logic [215:0]  s_tdata,
	// kind
	input  logic [1:0]    s_tuser,
	output logic          q_valid,
	output tet_pkg::cmd_t q_cmd,
	input  logic          q_pop
);

	tet_pkg::cmd_t                   fifo_q [tet_pkg::QDEPTH];
	logic [tet_pkg::QPTR_W-1:0]      wr_ptr_q;
	logic [tet_pkg::QPTR_W-1:0]      rd_ptr_q;
	logic [tet_pkg::QCNT_W-1:0]      cnt_q;
	tet_pkg::cmd_t                   cmd_in;
	logic                            push;

	// Unpack the transfer into a command
	always_comb begin
		cmd_in.op         = tet_pkg::kind_t'(s_tuser);
		cmd_in.now_ms     = s_tdata[31:0];
		cmd_in.secs       = s_tdata[95:32];
		cmd_in.etype      = s_tdata[98:96];
		cmd_in.node       = s_tdata[114:99];
		cmd_in.delay      = s_tdata[146:115];
		cmd_in.period     = s_tdata[178:147];
		cmd_in.slot       = s_tdata[182:179];
		cmd_in.due        = s_tdata[214:183];
		cmd_in.active_bit = s_tdata[215];
	end

	assign s_tready = (cnt_q != tet_pkg::QCNT_W'(tet_pkg::QDEPTH));
	assign push     = s_tvalid && s_tready;
	assign q_valid  = (cnt_q != '0);
	assign q_cmd    = fifo_q[rd_ptr_q];

	// Advance queue pointers and fill count
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_ptr_q <= '0;
			rd_ptr_q <= '0;
			cnt_q    <= '0;
		end else begin
			if (push) begin
				wr_ptr_q <= wr_ptr_q + 1'b1;
			end
			if (q_pop) begin
				rd_ptr_q <= rd_ptr_q + 1'b1;
			end
			if (push && !q_pop) begin
				cnt_q <= cnt_q + 1'b1;
			end else if (!push && q_pop) begin
				cnt_q <= cnt_q - 1'b1;
			end
		end
	end

	// Store commands
	always_ff @(posedge clk) begin
		if (push) begin
			fifo_q[wr_ptr_q] <= cmd_in;
		end
	end

	`TET_NEVER(a_pop_empty, q_pop && (cnt_q == '0), "command popped from empty queue")
	`TET_ASSERT(a_cnt_range, cnt_q <= tet_pkg::QCNT_W'(tet_pkg::QDEPTH), "queue overfilled")

endmodule

[design/tet_back.sv]
// ----------------------------------------------------------------------------
// tet_back
// Executes queued commands on the entry table and drives the result stream.
// ----------------------------------------------------------------------------
`include "assert_macros.svh"

module tet_back (
	input  logic          clk,
	input  logic          arst_n,
	input  logic          q_valid,
	input  tet_pkg::cmd_t q_cmd,
	output logic          q_pop,
	output logic          m_tvalid,
	input  logic          m_tready,
	// fired_node, fire_seconds_bits
	output logic [79:0]   m_tdata,
	// status
	output logic [2:0]    m_tuser,
	output logic          m_tlast
);

	tet_pkg::bstate_t            state_q, state_d;
	tet_pkg::cmd_t               cmd_q;
	logic [tet_pkg::CNT_W-1:0]   count_q;
	logic [tet_pkg::CNT_W-1:0]   idx_q;
	logic [2:0]                  resp_q;
	logic                        pend_vld_q;
	logic [15:0]                 pend_node_q;

	logic                        out_vld_q;
	logic [2:0]                  out_stat_q;
	logic [15:0]                 out_node_q;
	logic [63:0]                 out_secs_q;
	logic                        out_last_q;
	logic                        out_free;

	// RAM ports
	logic                        ram_we;
	logic [tet_pkg::IDX_W-1:0]   ram_waddr;
	tet_pkg::entry_t             ram_wdata;
	logic [tet_pkg::IDX_W-1:0]   ram_ra;
	logic [tet_pkg::IDX_W-1:0]   ram_rb;
	logic [tet_pkg::ENTRY_W-1:0] ram_rd_a;
	logic [tet_pkg::ENTRY_W-1:0] ram_rd_b;

	// Sequencer strobes
	logic                        cmd_load;
	logic                        cnt_inc;
	logic                        cnt_dec;
	logic                        idx_inc;
	logic                        idx_clr;
	logic                        pend_load;
	logic                        pend_clr;
	logic                        resp_load;
	logic [2:0]                  resp_val;
	logic                        emit;
	logic [2:0]                  emit_stat;
	logic [15:0]                 emit_node;
	logic [63:0]                 emit_secs;
	logic                        emit_last;

	// Walk evaluation
	tet_pkg::entry_t             ent;
	tet_pkg::entry_t             lst;
	tet_pkg::entry_t             ent_upd;
	tet_pkg::entry_t             ent_rmw;
	tet_pkg::entry_t             ent_new;
	logic                        live;
	logic                        arm_now;
	logic                        eff_armed;
	logic [31:0]                 eff_due;
	logic                        fire;
	logic                        fire_remove;
	logic                        slot_bad;
	logic                        tbl_full;
	logic                        walk_done;
	logic                        eval_stall;
	logic [tet_pkg::IDX_W-1:0]   last_idx;
	logic [tet_pkg::IDX_W-1:0]   slot_idx;

	tet_ram #(
		.WIDTH(tet_pkg::ENTRY_W),
		.DEPTH(tet_pkg::ENTRIES)
	) u_ram (
		.clk     (clk),
		.we      (ram_we),
		.waddr   (ram_waddr),
		.wdata   (ram_wdata),
		.raddr_a (ram_ra),
		.rdata_a (ram_rd_a),
		.raddr_b (ram_rb),
		.rdata_b (ram_rd_b)
	);

	assign out_free  = !out_vld_q || m_tready;
	assign last_idx  = tet_pkg::IDX_W'(count_q - tet_pkg::CNT_W'(1));
	assign slot_idx  = tet_pkg::IDX_W'(cmd_q.slot);
	assign slot_bad  = (32'(cmd_q.slot) >= 32'(count_q));
	assign tbl_full  = (32'(count_q) >= 32'(tet_pkg::ENTRIES));
	assign walk_done = (idx_q >= count_q);

	// Evaluate the entry under the walk: arm, test due, choose the update
	always_comb begin
		ent  = tet_pkg::entry_t'(ram_rd_a);
		lst  = tet_pkg::entry_t'(ram_rd_b);
		live = ent.active && (ent.etype <= tet_pkg::EV_REPEAT);
		arm_now = !ent.armed && ((ent.etype == tet_pkg::EV_ONESHOT) ||
			(ent.etype == tet_pkg::EV_REPEAT) || (ent.etype == tet_pkg::EV_DELAYED));
		eff_armed = ent.armed || arm_now;
		if (ent.armed) begin
			eff_due = ent.due;
		end else if (ent.etype == tet_pkg::EV_DELAYED) begin
			eff_due = cmd_q.now_ms + ent.delay;
		end else begin
			eff_due = cmd_q.now_ms;
		end
		fire = live && eff_armed && (cmd_q.now_ms >= eff_due);
		fire_remove = fire && (ent.etype != tet_pkg::EV_COOLDOWN) &&
			(ent.etype != tet_pkg::EV_REPEAT);
		ent_upd = ent;
		ent_upd.armed = eff_armed;
		ent_upd.due   = eff_due;
		if (fire && (ent.etype == tet_pkg::EV_COOLDOWN)) begin
			ent_upd.armed = 1'b0;
		end
		if (fire && (ent.etype == tet_pkg::EV_REPEAT)) begin
			ent_upd.due = cmd_q.now_ms + ent.period;
		end
		eval_stall = fire && pend_vld_q && !out_free;
	end

	// Build entries for add and for arm or activate
	always_comb begin
		ent_new.etype  = cmd_q.etype;
		ent_new.active = 1'b1;
		ent_new.armed  = 1'b0;
		ent_new.due    = '0;
		ent_new.node   = cmd_q.node;
		ent_new.delay  = cmd_q.delay;
		ent_new.period = cmd_q.period;
		ent_rmw = tet_pkg::entry_t'(ram_rd_a);
		if (cmd_q.op == tet_pkg::KIND_ARM) begin
			ent_rmw.due   = cmd_q.due;
			ent_rmw.armed = 1'b1;
		end else begin
			ent_rmw.active = cmd_q.active_bit;
		end
	end

	// Next state
	always_comb begin
		state_d = state_q;
		case (state_q)
			tet_pkg::BS_IDLE: begin
				if (q_valid) begin
					state_d = tet_pkg::BS_CMD;
				end
			end
			tet_pkg::BS_CMD: begin
				case (cmd_q.op)
					tet_pkg::KIND_TICK: state_d = tet_pkg::BS_WALK;
					tet_pkg::KIND_ADD:  state_d = tet_pkg::BS_RESP;
					tet_pkg::KIND_ARM, tet_pkg::KIND_ACT: begin
						state_d = slot_bad ? tet_pkg::BS_RESP : tet_pkg::BS_RMW;
					end
					default: state_d = tet_pkg::BS_RESP;
				endcase
			end
			tet_pkg::BS_RMW:  state_d = tet_pkg::BS_RESP;
			tet_pkg::BS_RESP: begin
				if (out_free) begin
					state_d = tet_pkg::BS_IDLE;
				end
			end
			tet_pkg::BS_WALK: begin
				state_d = walk_done ? tet_pkg::BS_TEND : tet_pkg::BS_EVAL;
			end
			tet_pkg::BS_EVAL: begin
				if (!eval_stall) begin
					state_d = tet_pkg::BS_WALK;
				end
			end
			tet_pkg::BS_TEND: begin
				if (out_free) begin
					state_d = tet_pkg::BS_IDLE;
				end
			end
			default: state_d = tet_pkg::BS_IDLE;
		endcase
	end

	// Sequencer outputs
	always_comb begin
		q_pop     = 1'b0;
		cmd_load  = 1'b0;
		cnt_inc   = 1'b0;
		cnt_dec   = 1'b0;
		idx_inc   = 1'b0;
		idx_clr   = 1'b0;
		pend_load = 1'b0;
		pend_clr  = 1'b0;
		resp_load = 1'b0;
		resp_val  = tet_pkg::STAT_WRITTEN;
		ram_we    = 1'b0;
		ram_waddr = idx_q[tet_pkg::IDX_W-1:0];
		ram_wdata = ent_upd;
		ram_ra    = idx_q[tet_pkg::IDX_W-1:0];
		ram_rb    = last_idx;
		emit      = 1'b0;
		emit_stat = tet_pkg::STAT_FIRED;
		emit_node = '0;
		emit_secs = '0;
		emit_last = 1'b1;
		case (state_q)
			tet_pkg::BS_IDLE: begin
				q_pop    = q_valid;
				cmd_load = q_valid;
			end
			tet_pkg::BS_CMD: begin
				case (cmd_q.op)
					tet_pkg::KIND_TICK: begin
						idx_clr  = 1'b1;
						pend_clr = 1'b1;
					end
					tet_pkg::KIND_ADD: begin
						resp_load = 1'b1;
						if (tbl_full) begin
							resp_val = tet_pkg::STAT_FULL;
						end else begin
							resp_val  = tet_pkg::STAT_ADDED;
							ram_we    = 1'b1;
							ram_waddr = tet_pkg::IDX_W'(count_q);
							ram_wdata = ent_new;
							cnt_inc   = 1'b1;
						end
					end
					default: begin
						// arm or activate: read the slot, or refuse a dead one
						ram_ra = slot_idx;
						if (slot_bad) begin
							resp_load = 1'b1;
							resp_val  = tet_pkg::STAT_BADSLOT;
						end
					end
				endcase
			end
			tet_pkg::BS_RMW: begin
				ram_we    = 1'b1;
				ram_waddr = slot_idx;
				ram_wdata = ent_rmw;
				resp_load = 1'b1;
				resp_val  = tet_pkg::STAT_WRITTEN;
			end
			tet_pkg::BS_RESP: begin
				emit      = out_free;
				emit_stat = resp_q;
			end
			tet_pkg::BS_EVAL: begin
				if (!eval_stall) begin
					if (fire) begin
						// flush the previous firing; this one stays pending
						emit      = pend_vld_q;
						emit_node = pend_node_q;
						emit_secs = cmd_q.secs;
						emit_last = 1'b0;
						pend_load = 1'b1;
					end
					if (fire_remove) begin
						// move the last entry into this slot and revisit it
						ram_we    = 1'b1;
						ram_wdata = lst;
						cnt_dec   = 1'b1;
					end else begin
						ram_we  = live;
						idx_inc = 1'b1;
					end
				end
			end
			tet_pkg::BS_TEND: begin
				emit = out_free;
				if (pend_vld_q) begin
					emit_node = pend_node_q;
					emit_secs = cmd_q.secs;
				end else begin
					emit_stat = tet_pkg::STAT_NOTHING;
				end
				pend_clr = out_free;
			end
			default: begin
			end
		endcase
	end

	// Control registers
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q    <= tet_pkg::BS_IDLE;
			count_q    <= '0;
			pend_vld_q <= 1'b0;
			out_vld_q  <= 1'b0;
		end else begin
			state_q <= state_d;
			if (cnt_inc) begin
				count_q <= count_q + 1'b1;
			end else if (cnt_dec) begin
				count_q <= count_q - 1'b1;
			end
			if (pend_clr) begin
				pend_vld_q <= 1'b0;
			end else if (pend_load) begin
				pend_vld_q <= 1'b1;
			end
			if (emit) begin
				out_vld_q <= 1'b1;
			end else if (m_tready) begin
				out_vld_q <= 1'b0;
			end
		end
	end

	// Payload registers
	always_ff @(posedge clk) begin
		if (cmd_load) begin
			cmd_q <= q_cmd;
		end
		if (idx_clr) begin
			idx_q <= '0;
		end else if (idx_inc) begin
			idx_q <= idx_q + 1'b1;
		end
		if (resp_load) begin
			resp_q <= resp_val;
		end
		if (pend_load) begin
			pend_node_q <= ent.node;
		end
		if (emit) begin
			out_stat_q <= emit_stat;
			out_node_q <= emit_node;
			out_secs_q <= emit_secs;
			out_last_q <= emit_last;
		end
	end

	assign m_tvalid = out_vld_q;
	assign m_tdata  = {out_secs_q, out_node_q};
	assign m_tuser  = out_stat_q;
	assign m_tlast  = out_last_q;

	`TET_ASSERT(a_count_max, count_q <= tet_pkg::CNT_W'(tet_pkg::ENTRIES), "entry count beyond table")
	`TET_ASSERT(a_eval_idx, (state_q == tet_pkg::BS_EVAL) |-> (idx_q < count_q), "walk index past live entries")
	`TET_ASSERT(a_zero_payload, (out_vld_q && (out_stat_q != tet_pkg::STAT_FIRED)) |-> (m_tdata == '0), "nonzero payload on non-firing result")

endmodule

[design/timed_event_table.sv]
// ----------------------------------------------------------------------------
// timed_event_table
// Table of timed events: add, arm and activate entries; a tick walks the
// table, arms, fires, swap-removes, disarms or rearms due entries.
// ----------------------------------------------------------------------------
//  channel | dir | tvalid/tready       | tdata                        | tuser  | tlast
//  s_      | in  | s_tvalid/s_tready   | input fields, 216 bits       | kind   | -
//  m_      | out | m_tvalid/m_tready   | fired_node, fire_seconds_bits| status | last result
//
// An add runs a command and a response state; arm or activate on a live slot adds
// a read-modify-write state. A tick walks the table: each visit costs a registered
// entry RAM read and an evaluate and write-back step, and a removal revisits its
// slot with one entry fewer left. A two-deep command queue lets input transfers
// continue while the back end works. Reset clears the entry count and all handshake
// state; the entry RAM holds no reset value and needs no clearing pass. A stalled
// output holds the walk only when a second firing must be pushed out.
// ----------------------------------------------------------------------------
module timed_event_table (
	input  logic         clk,
	input  logic         arst_n,
	input  logic         s_tvalid,
	output logic         s_tready,
	// now_ms[31:0], now_seconds_bits[95:32], event_type[98:96],
	// target_node[114:99], event_delay[146:115], period_ms[178:147],
	// slot[182:179], due_ms[214:183], active_bit[215]
	input  logic [215:0] s_tdata,
	// kind[1:0]
	input  logic [1:0]   s_tuser,
	output logic         m_tvalid,
	input  logic         m_tready,
	// fired_node[15:0], fire_seconds_bits[79:16]
	output logic [79:0]  m_tdata,
	// status[2:0]
	output logic [2:0]   m_tuser,
	output logic         m_tlast
);

	logic          q_valid;
	logic          q_pop;
	tet_pkg::cmd_t q_cmd;

	tet_front u_front (
		.clk      (clk),
		.arst_n   (arst_n),
		.s_tvalid (s_tvalid),
		.s_tready (s_tready),
		.s_tdata  (s_tdata),
		.s_tuser  (s_tuser),
		.q_valid  (q_valid),
		.q_cmd    (q_cmd),
		.q_pop    (q_pop)
	);

	tet_back u_back (
		.clk      (clk),
		.arst_n   (arst_n),
		.q_valid  (q_valid),
		.q_cmd    (q_cmd),
		.q_pop    (q_pop),
		.m_tvalid (m_tvalid),
		.m_tready (m_tready),
		.m_tdata  (m_tdata),
		.m_tuser  (m_tuser),
		.m_tlast  (m_tlast)
	);

endmodule

[test/tb_timed_event_table.sv]
// ----------------------------------------------------------------------------
// tb_timed_event_table
// Self-checking bench for the timed event table.
// A short directed table of items (empty-table errors, filling the table with
// every event type, the full-table refusal, arm and activate writes, ticks at
// the edges of the time range) is followed by random traffic shaped to keep
// the table churning. Every accepted item updates a shadow copy of the table,
// which queues the reports the block owes. Each output transfer is compared
// with the oldest queued report. Both ports idle at random, with one stretch
// that runs at full rate.
// ----------------------------------------------------------------------------
module tb_timed_event_table;
	timeunit 1ns;
	timeprecision 1ps;

	localparam int RANDOM_ITEMS   = 480;
	localparam int STEADY_FIRST   = 180;
	localparam int STEADY_LAST    = 260;
	localparam int IDLE_PCT       = 21;
	localparam int DRAIN_CYCLES   = 100;
	localparam int WATCHDOG_LIMIT = 4000;

	// Input fields as packed on s_tdata, last field first
	typedef struct packed {
		logic        active_bit;
		logic [31:0] due;
		logic [3:0]  slot;
		logic [31:0] period;
		logic [31:0] delay;
		logic [15:0] node;
		logic [2:0]  etype;
		logic [63:0] secs;
		logic [31:0] now_ms;
	} item_t;

	typedef struct {
		tet_pkg::kind_t kind;
		item_t          body;
		bit             hand;
		logic [2:0]     hand_stat;
	} row_t;

	typedef struct {
		logic [2:0]  status;
		logic [15:0] node;
		logic [63:0] secs;
		logic        last;
	} report_t;

	logic         clk;
	logic         arst_n = 1'b0;
	logic         s_tvalid = 1'b0;
	logic         s_tready;
	logic [215:0] s_tdata = '0;
	logic [1:0]   s_tuser = '0;
	logic         m_tvalid;
	logic         m_tready = 1'b0;
	logic [79:0]  m_tdata;
	logic [2:0]   m_tuser;
	logic         m_tlast;

	// Hand-typed expectation for the row on the bus
	bit           row_hand = 1'b0;
	logic [2:0]   row_hand_stat = tet_pkg::STAT_FIRED;
	bit           steady = 1'b0;

	// Shadow copy of the event table
	int           shadow_count;
	logic [2:0]   sh_type[tet_pkg::ENTRIES];
	logic         sh_active[tet_pkg::ENTRIES];
	logic         sh_armed[tet_pkg::ENTRIES];
	logic [31:0]  sh_due[tet_pkg::ENTRIES];
	logic [15:0]  sh_node[tet_pkg::ENTRIES];
	logic [31:0]  sh_delay[tet_pkg::ENTRIES];
	logic [31:0]  sh_period[tet_pkg::ENTRIES];

	report_t      pending_reports[$];
	row_t         directed_rows[$];
	logic [31:0]  clock_ms;
	int           errors;
	int           items_taken;
	int           idle_cycles;
	int           seen_status[8];

	timed_event_table dut (
		.clk      (clk),
		.arst_n   (arst_n),
		.s_tvalid (s_tvalid),
		.s_tready (s_tready),
		.s_tdata  (s_tdata),
		.s_tuser  (s_tuser),
		.m_tvalid (m_tvalid),
		.m_tready (m_tready),
		.m_tdata  (m_tdata),
		.m_tuser  (m_tuser),
		.m_tlast  (m_tlast)
	);

	initial begin
		clk = 1'b0;
		forever #2 clk = ~clk;
	end

	function automatic void push_report(logic [2:0] st, logic [15:0] node, logic [63:0] secs,
		logic last);
		report_t r;
		r.status = st;
		r.node   = node;
		r.secs   = secs;
		r.last   = last;
		pending_reports.push_back(r);
	endfunction

	// Apply one item to the shadow table and queue the reports it causes
	task automatic update_shadow_table(input tet_pkg::kind_t kind, input item_t it,
		input bit keep);
		logic [15:0] fired_nodes[$];
		logic [2:0]  t;
		logic [2:0]  st;
		bit          fire;
		int          i;
		if (kind == tet_pkg::KIND_TICK) begin
			i = 0;
			while (i < shadow_count) begin
				t = sh_type[i];
				if (!sh_active[i] || t > tet_pkg::EV_REPEAT) begin
					i++;
				end else begin
					// arm fresh one-shot, repeating and delayed entries
					if (!sh_armed[i]) begin
						if (t == tet_pkg::EV_ONESHOT || t == tet_pkg::EV_REPEAT) begin
							sh_due[i]   = it.now_ms;
							sh_armed[i] = 1'b1;
						end else if (t == tet_pkg::EV_DELAYED) begin
							sh_due[i]   = it.now_ms + sh_delay[i];
							sh_armed[i] = 1'b1;
						end
					end
					fire = sh_armed[i] && (it.now_ms >= sh_due[i]);
					if (!fire) begin
						i++;
					end else begin
						if (fired_nodes.size() < tet_pkg::MAX_RESULTS)
							fired_nodes.push_back(sh_node[i]);
						if (t == tet_pkg::EV_COOLDOWN) begin
							sh_armed[i] = 1'b0;
							i++;
						end else if (t == tet_pkg::EV_REPEAT) begin
							sh_due[i] = it.now_ms + sh_period[i];
							i++;
						end else begin
							// swap-remove; the moved entry is visited next
							shadow_count--;
							sh_type[i]   = sh_type[shadow_count];
							sh_active[i] = sh_active[shadow_count];
							sh_armed[i]  = sh_armed[shadow_count];
							sh_due[i]    = sh_due[shadow_count];
							sh_node[i]   = sh_node[shadow_count];
							sh_delay[i]  = sh_delay[shadow_count];
							sh_period[i] = sh_period[shadow_count];
						end
					end
				end
			end
			if (keep) begin
				if (fired_nodes.size() == 0)
					push_report(tet_pkg::STAT_NOTHING, '0, '0, 1'b1);
				for (int k = 0; k < fired_nodes.size(); k++)
					push_report(tet_pkg::STAT_FIRED, fired_nodes[k], it.secs,
						k == fired_nodes.size() - 1);
			end
		end else begin
			if (kind == tet_pkg::KIND_ADD) begin
				if (shadow_count >= tet_pkg::ENTRIES) begin
					st = tet_pkg::STAT_FULL;
				end else begin
					sh_type[shadow_count]   = it.etype;
					sh_node[shadow_count]   = it.node;
					sh_delay[shadow_count]  = it.delay;
					sh_period[shadow_count] = it.period;
					sh_active[shadow_count] = 1'b1;
					sh_armed[shadow_count]  = 1'b0;
					sh_due[shadow_count]    = '0;
					shadow_count++;
					st = tet_pkg::STAT_ADDED;
				end
			end else if (it.slot >= shadow_count) begin
				st = tet_pkg::STAT_BADSLOT;
			end else begin
				if (kind == tet_pkg::KIND_ARM) begin
					sh_due[it.slot]   = it.due;
					sh_armed[it.slot] = 1'b1;
				end else begin
					sh_active[it.slot] = it.active_bit;
				end
				st = tet_pkg::STAT_WRITTEN;
			end
			if (keep)
				push_report(st, '0, '0, 1'b1);
		end
	endtask

	task automatic add_row(input tet_pkg::kind_t kind, input logic [31:0] now_ms,
		input logic [63:0] secs, input logic [2:0] etype, input logic [15:0] node,
		input logic [31:0] delay, input logic [31:0] period, input logic [3:0] slot,
		input logic [31:0] due, input logic active_bit, input bit hand,
		input logic [2:0] hand_stat);
		row_t r;
		r.kind            = kind;
		r.body.now_ms     = now_ms;
		r.body.secs       = secs;
		r.body.etype      = etype;
		r.body.node       = node;
		r.body.delay      = delay;
		r.body.period     = period;
		r.body.slot       = slot;
		r.body.due        = due;
		r.body.active_bit = active_bit;
		r.hand            = hand;
		r.hand_stat       = hand_stat;
		directed_rows.push_back(r);
	endtask

	// Draw a random item, mostly aimed at live slots and a moving clock
	task automatic draw_row(output row_t r);
		logic [223:0] noise;
		int           pick;
		noise = {$urandom, $urandom, $urandom, $urandom, $urandom, $urandom, $urandom};
		r.body      = noise[215:0];
		r.hand      = 1'b0;
		r.hand_stat = tet_pkg::STAT_FIRED;
		pick = $urandom_range(0, 99);
		if (pick < 35) begin
			r.kind = tet_pkg::KIND_TICK;
			if ($urandom_range(0, 9) == 0)
				clock_ms = $urandom;
			else
				clock_ms = clock_ms + $urandom_range(0, 40);
			r.body.now_ms = clock_ms;
		end else if (pick < 65) begin
			r.kind = tet_pkg::KIND_ADD;
			// keep long-lived entries from clogging the table
			if (shadow_count > 10) begin
				case ($urandom_range(0, 3))
					0: r.body.etype = tet_pkg::EV_ONESHOT;
					1: r.body.etype = tet_pkg::EV_DELAYED;
					2: r.body.etype = tet_pkg::EV_ONLOAD;
					default: r.body.etype = tet_pkg::EV_ONCLEAR;
				endcase
			end
			if ($urandom_range(0, 7) != 0)
				r.body.delay = $urandom_range(0, 60);
			if ($urandom_range(0, 7) != 0)
				r.body.period = $urandom_range(0, 60);
		end else begin
			r.kind = (pick < 85) ? tet_pkg::KIND_ARM : tet_pkg::KIND_ACT;
			if (shadow_count > 0 && $urandom_range(0, 9) != 0)
				r.body.slot = 4'($urandom_range(0, shadow_count - 1));
			if ($urandom_range(0, 4) != 0)
				r.body.due = clock_ms + $urandom_range(0, 50);
			if ($urandom_range(0, 3) != 0)
				r.body.active_bit = 1'b1;
		end
	endtask

	// Present one item and hold it until the transfer
	task automatic send_row(input row_t r);
		int gap;
		gap = 0;
		while (!steady && $urandom_range(0, 99) < IDLE_PCT)
			gap++;
		if (gap > 0) begin
			s_tvalid <= 1'b0;
			repeat (gap) @(negedge clk);
		end
		s_tvalid      <= 1'b1;
		s_tdata       <= r.body;
		s_tuser       <= r.kind;
		row_hand      <= r.hand;
		row_hand_stat <= r.hand_stat;
		forever begin
			@(posedge clk);
			if (s_tready)
				break;
		end
		@(negedge clk);
	endtask

	// Stall the result port at random
	always @(negedge clk)
		m_tready <= steady || ($urandom_range(0, 99) >= IDLE_PCT);

	// Predict on input transfers, check output transfers, watch for hangs
	always @(posedge clk) begin : port_watch
		item_t   it;
		report_t got;
		report_t want;
		if (arst_n) begin
			if (s_tvalid && s_tready) begin
				it = s_tdata;
				update_shadow_table(tet_pkg::kind_t'(s_tuser), it, !row_hand);
				if (row_hand)
					push_report(row_hand_stat, '0, '0, 1'b1);
				items_taken++;
			end
			if (m_tvalid && m_tready) begin
				got.status = m_tuser;
				got.node   = m_tdata[15:0];
				got.secs   = m_tdata[79:16];
				got.last   = m_tlast;
				if (!$isunknown(got.status))
					seen_status[got.status]++;
				if (pending_reports.size() == 0) begin
					errors++;
					$display("%0t: unexpected result status %0d node %h secs %h last %b",
						$time, got.status, got.node, got.secs, got.last);
				end else begin
					want = pending_reports.pop_front();
					if (got.status !== want.status || got.node !== want.node ||
						got.secs !== want.secs || got.last !== want.last) begin
						errors++;
						$display("%0t: mismatch expected status %0d node %h secs %h last %b",
							$time, want.status, want.node, want.secs, want.last);
						$display("%0t:          actual   status %0d node %h secs %h last %b",
							$time, got.status, got.node, got.secs, got.last);
					end
				end
			end
			// count cycles with no transfer on either port
			if ((s_tvalid && s_tready) || (m_tvalid && m_tready))
				idle_cycles = 0;
			else
				idle_cycles++;
			if (idle_cycles >= WATCHDOG_LIMIT) begin
				$display("%0t: no transfer for %0d cycles, %0d results outstanding",
					$time, idle_cycles, pending_reports.size());
				$display("CHECKS FAILED");
				$finish;
			end
		end
	end

	initial begin : stimulus
		row_t r;
		errors       = 0;
		items_taken  = 0;
		idle_cycles  = 0;
		shadow_count = 0;
		clock_ms     = '0;
		foreach (seen_status[k])
			seen_status[k] = 0;

		// Errors on the empty table, then fill it with every event type
		add_row(tet_pkg::KIND_TICK, '0, '0, tet_pkg::EV_ONESHOT, '0, '0, '0, '0, '0, 1'b0,
			1'b1, tet_pkg::STAT_NOTHING);
		add_row(tet_pkg::KIND_ARM, '0, '0, tet_pkg::EV_ONESHOT, '0, '0, '0, 4'd0, '1, 1'b1,
			1'b1, tet_pkg::STAT_BADSLOT);
		add_row(tet_pkg::KIND_ACT, '0, '0, tet_pkg::EV_ONESHOT, '0, '0, '0, 4'd15, '0, 1'b1,
			1'b1, tet_pkg::STAT_BADSLOT);
		for (int i = 0; i < tet_pkg::ENTRIES; i++)
			add_row(tet_pkg::KIND_ADD, '0, '0, 3'(i % 8), 16'hFFFF - 16'(i * 16'h1111),
				(i == 1) ? 32'hFFFF_FFFF : (i == 9) ? 32'd0 : 32'(i * 3),
				(i == 5) ? 32'hFFFF_FFFF : (i == 13) ? 32'd0 : 32'(i * 7),
				'0, '0, 1'b0, 1'b1, tet_pkg::STAT_ADDED);
		add_row(tet_pkg::KIND_ADD, '0, '0, tet_pkg::EV_ONESHOT, 16'h5A5A, '0, '0, '0, '0, 1'b0,
			1'b1, tet_pkg::STAT_FULL);
		// Arm a cooldown and an on-load entry, deactivate a one-shot
		add_row(tet_pkg::KIND_ARM, '0, '0, tet_pkg::EV_ONESHOT, '0, '0, '0, 4'd2, 32'd0, 1'b0,
			1'b1, tet_pkg::STAT_WRITTEN);
		add_row(tet_pkg::KIND_ARM, '0, '0, tet_pkg::EV_ONESHOT, '0, '0, '0, 4'd3, '1, 1'b0,
			1'b1, tet_pkg::STAT_WRITTEN);
		add_row(tet_pkg::KIND_ACT, '0, '0, tet_pkg::EV_ONESHOT, '0, '0, '0, 4'd8, '0, 1'b0,
			1'b1, tet_pkg::STAT_WRITTEN);
		// Ticks at the top and bottom of the time range
		add_row(tet_pkg::KIND_TICK, '1, '1, tet_pkg::EV_ONESHOT, '0, '0, '0, '0, '0, 1'b0,
			1'b0, tet_pkg::STAT_FIRED);
		add_row(tet_pkg::KIND_TICK, '0, '0, tet_pkg::EV_ONESHOT, '0, '0, '0, '0, '0, 1'b0,
			1'b0, tet_pkg::STAT_FIRED);

		// Hold reset, then release on a falling edge
		repeat (11) @(posedge clk);
		@(negedge clk);
		arst_n = 1'b1;
		@(negedge clk);

		foreach (directed_rows[k])
			send_row(directed_rows[k]);

		for (int n = 0; n < RANDOM_ITEMS; n++) begin
			steady = (n >= STEADY_FIRST && n < STEADY_LAST);
			draw_row(r);
			send_row(r);
		end
		steady   = 1'b0;
		s_tvalid <= 1'b0;

		// Drain owed results, then watch for strays
		while (pending_reports.size() != 0)
			@(posedge clk);
		repeat (DRAIN_CYCLES) @(posedge clk);

		$display("Run covered %0d items: %0d firings, %0d quiet ticks, %0d adds, %0d refused adds,",
			items_taken, seen_status[tet_pkg::STAT_FIRED], seen_status[tet_pkg::STAT_NOTHING],
			seen_status[tet_pkg::STAT_ADDED], seen_status[tet_pkg::STAT_FULL]);
		$display("%0d arm/activate writes and %0d writes to dead slots; %0d mismatches.",
			seen_status[tet_pkg::STAT_WRITTEN], seen_status[tet_pkg::STAT_BADSLOT], errors);
		if (errors == 0)
			$display("ALL CHECKS PASSED");
		else
			$display("CHECKS FAILED");
		$finish;
	end

endmodule

[timed_event_table.f]
+incdir+design
design/tet_pkg.sv
design/tet_ram.sv
design/tet_front.sv
design/tet_back.sv
design/timed_event_table.sv
test/tb_timed_event_table.sv
